// ===== sv/lsha_pkg.sv =====
`timescale 1ns / 1ps
// lsha_pkg: register indexes, alarm state and transition codes, and the alarm
// result word, shared by the alarm evaluator and the top level. No dependencies.

package lsha_pkg;

    localparam logic [2:0] REG_IN_LOW     = 3'd0;
    localparam logic [2:0] REG_IN_HIGH    = 3'd1;
    localparam logic [2:0] REG_OUT_LOW    = 3'd2;
    localparam logic [2:0] REG_OUT_HIGH   = 3'd3;
    localparam logic [2:0] REG_ALARM_ON   = 3'd4;
    localparam logic [2:0] REG_HI_THRESH  = 3'd5;
    localparam logic [2:0] REG_LO_THRESH  = 3'd6;
    localparam logic [2:0] REG_HYSTERESIS = 3'd7;

    localparam logic [1:0] LVL_OK   = 2'd0;
    localparam logic [1:0] LVL_HIGH = 2'd1;
    localparam logic [1:0] LVL_LOW  = 2'd2;

    localparam logic [1:0] CHG_NONE = 2'd0;
    localparam logic [1:0] CHG_HIGH = 2'd1;
    localparam logic [1:0] CHG_LOW  = 2'd2;
    localparam logic [1:0] CHG_OK   = 2'd3;

    typedef struct packed {
        logic [1:0] level;
        logic [1:0] change;
    } alarm_res_t;

endpackage

// ===== sv/lsha_div.sv =====
`timescale 1ns / 1ps
// lsha_div: iterative restoring divider, one quotient bit per cycle.
// 2W-bit dividend by W-bit divisor; caller guarantees the quotient fits W bits.

module lsha_div #(
    parameter int W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2*W-1:0]   dividend,
    input  logic [W-1:0]     divisor,
    output logic             done,
    output logic [W-1:0]     quotient
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] acc_next;
    logic [W-1:0]   div_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic [W:0]     part;
    logic [W:0]     diff;
    logic           fits;
    logic [W-1:0]   hi_new;

    // partial remainder stays below the divisor, so one subtract per bit
    assign part     = {acc_reg[2*W-1:W], acc_reg[W-1]};
    assign diff     = part - {1'b0, div_reg};
    assign fits     = ~diff[W];
    assign hi_new   = fits ? diff[W-1:0] : part[W-1:0];
    assign acc_next = {hi_new, acc_reg[W-2:0], fits};

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = acc_reg[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== sv/lsha_alarm.sv =====
`timescale 1ns / 1ps
// lsha_alarm: three-state hysteresis alarm, next state and transition kind.
// Depends on lsha_pkg for codes and the result word.

module lsha_alarm #(
    parameter int W = 16
) (
    input  logic signed [W-1:0] value,
    input  logic signed [W-1:0] hi_thresh,
    input  logic signed [W-1:0] lo_thresh,
    input  logic [W-2:0]        hysteresis,
    input  logic                alarm_on,
    input  logic [1:0]          level_now,
    output lsha_pkg::alarm_res_t res
);

    logic signed [W:0] ve;
    logic signed [W:0] hi_e;
    logic signed [W:0] lo_e;
    logic signed [W:0] hi_back;
    logic signed [W:0] lo_back;
    logic [1:0]        nxt;

    // limits widened by one bit so the hysteresis offsets cannot wrap
    assign ve      = {value[W-1], value};
    assign hi_e    = {hi_thresh[W-1], hi_thresh};
    assign lo_e    = {lo_thresh[W-1], lo_thresh};
    assign hi_back = hi_e - $signed({2'b00, hysteresis});
    assign lo_back = lo_e + $signed({2'b00, hysteresis});

    always_comb
    begin
        nxt = level_now;
        if (!alarm_on)
        begin
            nxt = lsha_pkg::LVL_OK;
        end
        else
        begin
            unique case (level_now)
                lsha_pkg::LVL_HIGH:
                begin
                    if (ve <= hi_back)
                        nxt = (ve <= lo_e) ? lsha_pkg::LVL_LOW : lsha_pkg::LVL_OK;
                end
                lsha_pkg::LVL_LOW:
                begin
                    if (ve >= lo_back)
                        nxt = (ve >= hi_e) ? lsha_pkg::LVL_HIGH : lsha_pkg::LVL_OK;
                end
                default:
                begin
                    if (ve >= hi_e)
                        nxt = lsha_pkg::LVL_HIGH;
                    else if (ve <= lo_e)
                        nxt = lsha_pkg::LVL_LOW;
                    else
                        nxt = lsha_pkg::LVL_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        res.level  = nxt;
        res.change = lsha_pkg::CHG_NONE;
        if (nxt != level_now)
        begin
            priority if (nxt == lsha_pkg::LVL_HIGH)
                res.change = lsha_pkg::CHG_HIGH;
            else if (nxt == lsha_pkg::LVL_LOW)
                res.change = lsha_pkg::CHG_LOW;
            else if ((level_now == lsha_pkg::LVL_HIGH) || (level_now == lsha_pkg::LVL_LOW))
                res.change = lsha_pkg::CHG_OK;
            else
                res.change = lsha_pkg::CHG_NONE;
        end
    end

endmodule

// ===== sv/linear_scale_hysteresis_alarm_core.sv =====
`timescale 1ns / 1ps
// linear_scale_hysteresis_alarm_core: linear range scaling with rounding and
// clamping, followed by a hysteresis alarm. Uses lsha_pkg, lsha_div, lsha_alarm.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid / in_ready    | raw_sample
//  output   | out_valid / out_ready  | scaled, alarm_level, alarm_change
//  config   | cfg_we                 | cfg_index, cfg_data
//
// One word at a time. Interior samples pass through the multiply and the
// one-bit-per-cycle divider before output valid; clamped samples and an empty
// input range skip both and go straight from setup to the value step.
// in_ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next accept, but a second finished result
// holds in the last step until the first is taken.
// Reset clears control state and loads the default register values.

module linear_scale_hysteresis_alarm_core #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] raw_sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] scaled,
    output logic [1:0]                   alarm_level,
    output logic [1:0]                   alarm_change,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data
);

    localparam int W = DATA_WIDTH;

    localparam int RST_IN_LOW     = 0;
    localparam int RST_IN_HIGH    = 4095;
    localparam int RST_OUT_LOW    = 0;
    localparam int RST_OUT_HIGH   = 1000;
    localparam int RST_HI_THRESH  = 800;
    localparam int RST_LO_THRESH  = 200;
    localparam int RST_HYSTERESIS = 50;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_VAL    = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic signed [W-1:0] in_low_reg;
    logic signed [W-1:0] in_high_reg;
    logic signed [W-1:0] out_low_reg;
    logic signed [W-1:0] out_high_reg;
    logic                alarm_on_reg;
    logic signed [W-1:0] hi_thresh_reg;
    logic signed [W-1:0] lo_thresh_reg;
    logic [W-2:0]        hysteresis_reg;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [1:0]          alarm_now_reg;
    logic                out_valid_reg;

    logic signed [W-1:0] raw_reg;
    logic [W-1:0]        a_reg;
    logic [W-1:0]        b_reg;
    logic [W-1:0]        dm_reg;
    logic                neg_reg;
    logic                direct_reg;
    logic signed [W-1:0] direct_val_reg;
    logic [2*W-1:0]      prod_reg;
    logic signed [W-1:0] v_reg;
    logic signed [W-1:0] scaled_reg;
    logic [1:0]          alarm_level_reg;
    logic [1:0]          alarm_change_reg;

    logic [W:0]          nd;
    logic [W:0]          dd;
    logic [W:0]          md;
    logic [W:0]          nd_mag;
    logic [W:0]          dd_mag;
    logic [W:0]          md_mag;
    logic                up;
    logic                clamp_lo;
    logic                clamp_hi;
    logic                direct;
    logic signed [W-1:0] direct_val;

    logic                div_start;
    logic                div_done;
    logic [2*W-1:0]      dividend;
    logic [W-1:0]        quotient;
    logic [W:0]          q_ext;
    logic [W:0]          val_sum;

    logic                take;
    lsha_pkg::alarm_res_t alarm_res;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_low_reg     <= W'(RST_IN_LOW);
            in_high_reg    <= W'(RST_IN_HIGH);
            out_low_reg    <= W'(RST_OUT_LOW);
            out_high_reg   <= W'(RST_OUT_HIGH);
            alarm_on_reg   <= 1'b0;
            hi_thresh_reg  <= W'(RST_HI_THRESH);
            lo_thresh_reg  <= W'(RST_LO_THRESH);
            hysteresis_reg <= (W-1)'(RST_HYSTERESIS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsha_pkg::REG_IN_LOW:     in_low_reg     <= cfg_data;
                lsha_pkg::REG_IN_HIGH:    in_high_reg    <= cfg_data;
                lsha_pkg::REG_OUT_LOW:    out_low_reg    <= cfg_data;
                lsha_pkg::REG_OUT_HIGH:   out_high_reg   <= cfg_data;
                lsha_pkg::REG_ALARM_ON:   alarm_on_reg   <= cfg_data[0];
                lsha_pkg::REG_HI_THRESH:  hi_thresh_reg  <= cfg_data;
                lsha_pkg::REG_LO_THRESH:  lo_thresh_reg  <= cfg_data;
                lsha_pkg::REG_HYSTERESIS: hysteresis_reg <= cfg_data[W-2:0];
                default:                  ;
            endcase
        end
    end

    // setup: offsets, magnitudes and clamp decisions
    assign nd = {raw_reg[W-1], raw_reg} - {in_low_reg[W-1], in_low_reg};
    assign dd = {in_high_reg[W-1], in_high_reg} - {in_low_reg[W-1], in_low_reg};
    assign md = {out_high_reg[W-1], out_high_reg} - {out_low_reg[W-1], out_low_reg};
    assign nd_mag = nd[W] ? (~nd + 1'b1) : nd;
    assign dd_mag = dd[W] ? (~dd + 1'b1) : dd;
    assign md_mag = md[W] ? (~md + 1'b1) : md;

    assign up       = in_high_reg > in_low_reg;
    assign clamp_lo = up ? (raw_reg <= in_low_reg) : (raw_reg >= in_low_reg);
    assign clamp_hi = up ? (raw_reg >= in_high_reg) : (raw_reg <= in_high_reg);

    always_comb
    begin
        direct     = 1'b1;
        direct_val = out_low_reg;
        priority if (in_low_reg == in_high_reg)
            direct_val = out_low_reg;
        else if (clamp_lo)
            direct_val = out_low_reg;
        else if (clamp_hi)
            direct_val = out_high_reg;
        else
            direct = 1'b0;
    end

    assign div_start = (state_reg == ST_DSTART);
    assign dividend  = prod_reg + (2*W)'(dm_reg >> 1);

    lsha_div #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dm_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_ext   = {1'b0, quotient};
    assign val_sum = {out_low_reg[W-1], out_low_reg} + (neg_reg ? (~q_ext + 1'b1) : q_ext);

    lsha_alarm #(
        .W (W)
    ) u_alarm (
        .value      (v_reg),
        .hi_thresh  (hi_thresh_reg),
        .lo_thresh  (lo_thresh_reg),
        .hysteresis (hysteresis_reg),
        .alarm_on   (alarm_on_reg),
        .level_now  (alarm_now_reg),
        .res        (alarm_res)
    );

    assign take = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_PREP;
            ST_PREP:   state_next = direct ? ST_VAL : ST_MUL;
            ST_MUL:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (div_done) state_next = ST_VAL;
            ST_VAL:    state_next = ST_FIN;
            ST_FIN:    if (take) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alarm_now_reg <= lsha_pkg::LVL_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                alarm_now_reg <= alarm_res.level;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
            raw_reg <= raw_sample;
        if (state_reg == ST_PREP)
        begin
            a_reg          <= nd_mag[W-1:0];
            b_reg          <= md_mag[W-1:0];
            dm_reg         <= dd_mag[W-1:0];
            neg_reg        <= (nd[W] ^ md[W]) ^ dd[W];
            direct_reg     <= direct;
            direct_val_reg <= direct_val;
        end
        if (state_reg == ST_MUL)
            prod_reg <= (2*W)'(a_reg) * (2*W)'(b_reg);
        if (state_reg == ST_VAL)
            v_reg <= direct_reg ? direct_val_reg : val_sum[W-1:0];
        if (take)
        begin
            scaled_reg       <= v_reg;
            alarm_level_reg  <= alarm_res.level;
            alarm_change_reg <= alarm_res.change;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign scaled       = scaled_reg;
    assign alarm_level  = alarm_level_reg;
    assign alarm_change = alarm_change_reg;

endmodule
